@@ rtl/rtc_pkg.sv @@
// rotor tracking controller package: field widths, codes and fixed limits
// used by rtc_div and rotor_tracking_controller; no dependencies
`default_nettype none

package rtc_pkg;

  // field widths
  localparam int unsigned POS_W  = 20;
  localparam int unsigned PER_W  = 12;
  localparam int unsigned DEG_W  = 9;
  localparam int unsigned ANG_W  = 10;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // divider sweep length, one quotient bit per cycle
  localparam int unsigned DIV_STEPS = POS_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // multiplier sweep length, one degree bit per cycle
  localparam int unsigned MUL_CNT_W = $clog2(DEG_W);

  // angle limits and tick step
  localparam logic [DEG_W-1:0] AZ_LOW_DEG   = DEG_W'(0);
  localparam logic [DEG_W-1:0] AZ_HIGH_DEG  = DEG_W'(360);
  localparam logic [DEG_W-1:0] EL_LOW_DEG   = DEG_W'(0);
  localparam logic [DEG_W-1:0] EL_HIGH_DEG  = DEG_W'(90);
  localparam logic [DEG_W-1:0] AZ_RANGE_DEG = DEG_W'(360);
  localparam logic [DEG_W-1:0] EL_RANGE_DEG = DEG_W'(90);
  localparam logic [POS_W-1:0] STEP_MS      = POS_W'(100);
  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
  localparam logic [ANG_W-1:0] ANG_MAX      = {ANG_W{1'b1}};

  // register reset values
  localparam logic [POS_W-1:0] AZ_TRAVEL_RST = POS_W'(60000);
  localparam logic [POS_W-1:0] EL_TRAVEL_RST = POS_W'(30000);
  localparam logic [POS_W-1:0] ERR_MIN_RST   = POS_W'(200);
  localparam logic [POS_W-1:0] ERR_MAX_RST   = POS_W'(500);
  localparam logic [PER_W-1:0] AZ_PER_RST    = PER_W'(166);
  localparam logic [PER_W-1:0] EL_PER_RST    = PER_W'(333);

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_SET_AZ  = 3'd1,
    KIND_SET_EL  = 3'd2,
    KIND_TRK_ON  = 3'd3,
    KIND_TRK_OFF = 3'd4,
    KIND_HOME    = 3'd5
  } kind_e;

  // register indexes
  typedef enum logic [2:0] {
    REG_AZ_TRAVEL  = 3'd0,
    REG_EL_TRAVEL  = 3'd1,
    REG_AZ_ERR_MIN = 3'd2,
    REG_AZ_ERR_MAX = 3'd3,
    REG_EL_ERR_MIN = 3'd4,
    REG_EL_ERR_MAX = 3'd5,
    REG_AZ_PER     = 3'd6,
    REG_EL_PER     = 3'd7
  } reg_idx_e;

  // drive states
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_REV  = 2'd2
  } mode_e;

  // divider handshake
  typedef struct packed {
    logic             done;
    logic [ANG_W-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

@@ rtl/rtc_div.sv @@
// bit-serial restoring divider: position over per-degree, saturated angle
// depends on rtc_pkg
`default_nettype none

module rtc_div (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire [rtc_pkg::POS_W-1:0] dividend_i,
  input  wire [rtc_pkg::PER_W-1:0] divisor_i,
  output rtc_pkg::div_res_t        res_o
);
  import rtc_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [POS_W-1:0]     dvd_q;
  logic [PER_W-1:0]     dvs_q;
  logic [PER_W-1:0]     rem_q;
  logic [ANG_W-1:0]     quo_q;
  logic                 ovf_q;
  logic                 done_q;

  logic [PER_W:0]       trial;
  logic [PER_W:0]       diff;
  logic                 qbit;

  // one trial subtract per cycle
  assign trial = {rem_q, dvd_q[POS_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[POS_W-2:0], 1'b0};
      rem_q <= qbit ? diff[PER_W-1:0] : trial[PER_W-1:0];
      quo_q <= {quo_q[ANG_W-2:0], qbit};
      ovf_q <= ovf_q | quo_q[ANG_W-1];
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = ovf_q ? ANG_MAX : quo_q;

endmodule

`default_nettype wire

@@ rtl/rotor_tracking_controller.sv @@
// two-axis rotor tracking controller, top level
// depends on rtc_pkg and rtc_div
//
// Each accepted item updates the dead-reckoning positions, goals and drive
// states, then yields one result with both drive states, both positions and
// both whole-degree angles. The angles come from one shared bit-serial
// divider, and a target goal comes from a bit-serial shift-add multiplier.
// A new item is taken once the previous one has finished computing, even
// if its result is still waiting in the output register; a result that is
// still stalled holds the next item in its final state, S_DONE. Registers
// sit on an APB port with pready tied high; write them only while no item
// is in flight.
`default_nettype none

module rotor_tracking_controller (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // item input
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire [rtc_pkg::KIND_W-1:0]  kind_i,
  input  wire [rtc_pkg::DEG_W-1:0]   degrees_i,
  // result output
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [1:0]                 az_drive_o,
  output logic [1:0]                 el_drive_o,
  output logic [rtc_pkg::POS_W-1:0]  az_position_o,
  output logic [rtc_pkg::POS_W-1:0]  el_position_o,
  output logic [rtc_pkg::ANG_W-1:0]  az_angle_o,
  output logic [rtc_pkg::ANG_W-1:0]  el_angle_o,
  // register port
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [rtc_pkg::ADDR_W-1:0]  paddr,
  input  wire [rtc_pkg::DATA_W-1:0]  pwdata,
  output logic [rtc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import rtc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DRIVE,
    S_DIV_AZ_GO,
    S_DIV_AZ_WAIT,
    S_DIV_EL_GO,
    S_DIV_EL_WAIT,
    S_DONE
  } state_e;

  // configuration registers
  logic [POS_W-1:0] az_travel_q, el_travel_q;
  logic [POS_W-1:0] az_err_min_q, az_err_max_q, el_err_min_q, el_err_max_q;
  logic [PER_W-1:0] az_per_q, el_per_q;

  // controller state
  state_e           state_q;
  kind_e            kind_q;
  logic [DEG_W-1:0] deg_q;
  logic [POS_W-1:0] az_est_q, el_est_q, az_goal_q, el_goal_q;
  mode_e            az_mode_q, el_mode_q;
  logic             track_q;
  logic             mul_el_q;
  logic [MUL_CNT_W-1:0] mul_cnt_q;
  logic [DEG_W-1:0] mul_deg_q;
  logic [PER_W-1:0] mul_per_q;
  logic [POS_W:0]   mul_acc_q;
  logic [ANG_W-1:0] az_ang_q;
  logic             out_valid_q;
  logic [1:0]       az_drive_q, el_drive_q;
  logic [POS_W-1:0] az_pos_q, el_pos_q;
  logic [ANG_W-1:0] az_ang_out_q, el_ang_out_q;
  logic [ANG_W-1:0] el_ang_shadow_q;

  logic [2:0]       reg_idx;
  logic             cfg_wr;
  logic             in_acc;
  logic             out_free;
  logic             div_start;
  logic [POS_W-1:0] div_dvd;
  logic [PER_W-1:0] div_dvs;
  div_res_t         div_res;
  logic [DEG_W-1:0] az_deg_cl, el_deg_cl;
  logic [POS_W:0]   mul_acc_d;

  // one tick of dead reckoning
  function automatic logic [POS_W-1:0] move_pos(
    input logic [POS_W-1:0] pos,
    input mode_e            mode,
    input logic [POS_W-1:0] top
  );
    logic [POS_W:0] sum;
    logic [POS_W-1:0] res;
    sum = {1'b0, pos} + {1'b0, STEP_MS};
    res = pos;
    if (mode == MODE_FWD && pos < top) begin
      res = (sum > {1'b0, top}) ? top : sum[POS_W-1:0];
    end else if (mode == MODE_REV && pos != '0) begin
      res = (pos < STEP_MS) ? '0 : pos - STEP_MS;
    end
    return res;
  endfunction

  // hysteresis drive machine, never reverses without passing idle
  function automatic mode_e drive_next(
    input mode_e            mode,
    input logic [POS_W-1:0] pos,
    input logic [POS_W-1:0] goal,
    input logic [POS_W-1:0] emin,
    input logic [POS_W-1:0] emax
  );
    logic [POS_W:0] pos_min, pos_max, goal_min, goal_max;
    mode_e          res;
    pos_min  = {1'b0, pos} + {1'b0, emin};
    pos_max  = {1'b0, pos} + {1'b0, emax};
    goal_min = {1'b0, goal} + {1'b0, emin};
    goal_max = {1'b0, goal} + {1'b0, emax};
    res = mode;
    if ({1'b0, goal} > pos_min) begin
      if (mode == MODE_IDLE) begin
        if ({1'b0, goal} > pos_max) res = MODE_FWD;
      end else if (mode == MODE_REV) begin
        res = MODE_IDLE;
      end
    end else if (goal_min < {1'b0, pos}) begin
      if (mode == MODE_IDLE) begin
        if (goal_max < {1'b0, pos}) res = MODE_REV;
      end else if (mode == MODE_FWD) begin
        res = MODE_IDLE;
      end
    end else begin
      res = MODE_IDLE;
    end
    return res;
  endfunction

  // register port
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_travel_q  <= AZ_TRAVEL_RST;
      el_travel_q  <= EL_TRAVEL_RST;
      az_err_min_q <= ERR_MIN_RST;
      az_err_max_q <= ERR_MAX_RST;
      el_err_min_q <= ERR_MIN_RST;
      el_err_max_q <= ERR_MAX_RST;
      az_per_q     <= AZ_PER_RST;
      el_per_q     <= EL_PER_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(reg_idx))
        REG_AZ_TRAVEL:  az_travel_q  <= pwdata[POS_W-1:0];
        REG_EL_TRAVEL:  el_travel_q  <= pwdata[POS_W-1:0];
        REG_AZ_ERR_MIN: az_err_min_q <= pwdata[POS_W-1:0];
        REG_AZ_ERR_MAX: az_err_max_q <= pwdata[POS_W-1:0];
        REG_EL_ERR_MIN: el_err_min_q <= pwdata[POS_W-1:0];
        REG_EL_ERR_MAX: el_err_max_q <= pwdata[POS_W-1:0];
        REG_AZ_PER:     az_per_q     <= pwdata[PER_W-1:0];
        REG_EL_PER:     el_per_q     <= pwdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx_e'(reg_idx))
      REG_AZ_TRAVEL:  prdata = DATA_W'(az_travel_q);
      REG_EL_TRAVEL:  prdata = DATA_W'(el_travel_q);
      REG_AZ_ERR_MIN: prdata = DATA_W'(az_err_min_q);
      REG_AZ_ERR_MAX: prdata = DATA_W'(az_err_max_q);
      REG_EL_ERR_MIN: prdata = DATA_W'(el_err_min_q);
      REG_EL_ERR_MAX: prdata = DATA_W'(el_err_max_q);
      REG_AZ_PER:     prdata = DATA_W'(az_per_q);
      REG_EL_PER:     prdata = DATA_W'(el_per_q);
      default:        prdata = '0;
    endcase
  end

  // handshakes
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // target clamping to the angle limits
  always_comb begin
    priority if (deg_q < AZ_LOW_DEG) az_deg_cl = AZ_LOW_DEG;
    else if (deg_q > AZ_HIGH_DEG)    az_deg_cl = AZ_HIGH_DEG;
    else                             az_deg_cl = deg_q;
    priority if (deg_q < EL_LOW_DEG) el_deg_cl = EL_LOW_DEG;
    else if (deg_q > EL_HIGH_DEG)    el_deg_cl = EL_HIGH_DEG;
    else                             el_deg_cl = deg_q;
  end

  // shift-add multiplier step, degree msb first
  assign mul_acc_d = {mul_acc_q[POS_W-1:0], 1'b0}
                   + (mul_deg_q[DEG_W-1] ? (POS_W+1)'(mul_per_q) : '0);

  // shared divider
  assign div_start = (state_q == S_DIV_AZ_GO) | (state_q == S_DIV_EL_GO);
  assign div_dvd   = (state_q == S_DIV_EL_GO) ? el_est_q : az_est_q;
  assign div_dvs   = (state_q == S_DIV_EL_GO) ? el_per_q : az_per_q;

  rtc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .res_o      (div_res)
  );

  // item sequencer, axis state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= KIND_TICK;
      deg_q        <= '0;
      az_est_q     <= '0;
      el_est_q     <= '0;
      az_goal_q    <= '0;
      el_goal_q    <= '0;
      az_mode_q    <= MODE_IDLE;
      el_mode_q    <= MODE_IDLE;
      track_q      <= 1'b0;
      mul_el_q     <= 1'b0;
      mul_cnt_q    <= '0;
      mul_deg_q    <= '0;
      mul_per_q    <= '0;
      mul_acc_q    <= '0;
      az_ang_q     <= '0;
      out_valid_q  <= 1'b0;
      az_drive_q   <= '0;
      el_drive_q   <= '0;
      az_pos_q     <= '0;
      el_pos_q     <= '0;
      az_ang_out_q <= '0;
      el_ang_out_q <= '0;
    end else begin
      // result taken and no new one handed over this cycle
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            kind_q  <= kind_e'(kind_i);
            deg_q   <= degrees_i;
            state_q <= S_EXEC;
          end
        end

        // apply the item
        S_EXEC: begin
          state_q <= S_DIV_AZ_GO;
          unique case (kind_q)
            KIND_TICK: begin
              az_est_q <= move_pos(az_est_q, az_mode_q, az_travel_q);
              el_est_q <= move_pos(el_est_q, el_mode_q, el_travel_q);
              if (track_q) state_q <= S_DRIVE;
            end
            KIND_SET_AZ: begin
              if (deg_q <= AZ_RANGE_DEG) begin
                mul_el_q  <= 1'b0;
                mul_deg_q <= az_deg_cl;
                mul_per_q <= az_per_q;
                mul_acc_q <= '0;
                mul_cnt_q <= MUL_CNT_W'(DEG_W - 1);
                state_q   <= S_MUL;
              end
            end
            KIND_SET_EL: begin
              if (deg_q <= EL_RANGE_DEG) begin
                mul_el_q  <= 1'b1;
                mul_deg_q <= el_deg_cl;
                mul_per_q <= el_per_q;
                mul_acc_q <= '0;
                mul_cnt_q <= MUL_CNT_W'(DEG_W - 1);
                state_q   <= S_MUL;
              end
            end
            KIND_TRK_ON:  track_q <= 1'b1;
            KIND_TRK_OFF: track_q <= 1'b0;
            KIND_HOME: begin
              track_q   <= 1'b0;
              az_est_q  <= '0;
              az_goal_q <= '0;
              el_est_q  <= el_travel_q;
              el_goal_q <= el_travel_q;
              az_mode_q <= MODE_IDLE;
              el_mode_q <= MODE_IDLE;
            end
            default: ;
          endcase
        end

        // goal multiply, saturated to the position width
        S_MUL: begin
          mul_acc_q <= mul_acc_d;
          mul_deg_q <= {mul_deg_q[DEG_W-2:0], 1'b0};
          mul_cnt_q <= mul_cnt_q - MUL_CNT_W'(1);
          if (mul_cnt_q == '0) begin
            if (mul_el_q) begin
              el_goal_q <= mul_acc_d[POS_W] ? POS_MAX : mul_acc_d[POS_W-1:0];
            end else begin
              az_goal_q <= mul_acc_d[POS_W] ? POS_MAX : mul_acc_d[POS_W-1:0];
            end
            state_q <= S_DIV_AZ_GO;
          end
        end

        // deadband decision on the moved positions
        S_DRIVE: begin
          az_mode_q <= drive_next(az_mode_q, az_est_q, az_goal_q,
                                  az_err_min_q, az_err_max_q);
          el_mode_q <= drive_next(el_mode_q, el_est_q, el_goal_q,
                                  el_err_min_q, el_err_max_q);
          state_q   <= S_DIV_AZ_GO;
        end

        S_DIV_AZ_GO: state_q <= S_DIV_AZ_WAIT;

        S_DIV_AZ_WAIT: begin
          if (div_res.done) begin
            az_ang_q <= div_res.quot;
            state_q  <= S_DIV_EL_GO;
          end
        end

        S_DIV_EL_GO: state_q <= S_DIV_EL_WAIT;

        S_DIV_EL_WAIT: begin
          if (div_res.done) begin
            el_ang_out_q <= div_res.quot;
            state_q      <= S_DONE;
          end
        end

        // hand the result over once the output register is free
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            az_drive_q   <= az_mode_q;
            el_drive_q   <= el_mode_q;
            az_pos_q     <= az_est_q;
            el_pos_q     <= el_est_q;
            az_ang_out_q <= az_ang_q;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign az_drive_o    = az_drive_q;
  assign el_drive_o    = el_drive_q;
  assign az_position_o = az_pos_q;
  assign el_position_o = el_pos_q;
  assign az_angle_o    = az_ang_out_q;
  // elevation angle lands while the previous result may still be stalled,
  // so it is staged with the rest of the result in S_DONE
  assign el_angle_o    = el_ang_shadow_q;

  // elevation angle staged with the rest of the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_ang_shadow_q <= '0;
    end else if (state_q == S_DONE && out_free) begin
      el_ang_shadow_q <= el_ang_out_q;
    end
  end

  // azimuth drive never goes from forward straight to reverse
  a_az_no_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(az_mode_q) == MODE_FWD) |-> (az_mode_q != MODE_REV))
    else $error("azimuth drive reversed without idle");

  // elevation drive never goes from reverse straight to forward
  a_el_no_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(el_mode_q) == MODE_REV) |-> (el_mode_q != MODE_FWD))
    else $error("elevation drive reversed without idle");

  // divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == S_DIV_AZ_WAIT || state_q == S_DIV_EL_WAIT))
    else $error("divider finished outside a wait state");

endmodule

`default_nettype wire
